@@ hdl/lszm_pkg.sv @@
// shared types and constants for the lidar safety zone monitor
`default_nettype none

package lszm_pkg;

    // beam table depth and its address width
    localparam int BEAMS  = 1024;
    localparam int ADDR_W = $clog2(BEAMS);

    // field widths
    localparam int BEAM_W   = 10;
    localparam int DIST_W   = 16;
    localparam int HITS_W   = 10;
    localparam int WINDOW_W = 11;
    localparam int HLIM_W   = 8;
    localparam int WLIM_W   = 10;
    localparam int LIMIT_W  = 2 * DIST_W;

    // saturation value of a window counter
    localparam logic [WINDOW_W-1:0] WINDOW_MAX = {WINDOW_W{1'b1}};

    // register reset values
    localparam logic [HLIM_W-1:0] HIT_LIMIT_RST    = 8'd20;
    localparam logic [WLIM_W-1:0] WINDOW_LIMIT_RST = 10'd300;
    localparam logic [DIST_W-1:0] NEAR_FLOOR_RST   = 16'd200;
    localparam logic [DIST_W-1:0] RANGE_FLOOR_RST  = 16'd50;

    // item kinds carried on tuser
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_TOGGLE = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_HIT_LIMIT    = 2'd0,
        CFG_WINDOW_LIMIT = 2'd1,
        CFG_NEAR_FLOOR   = 2'd2,
        CFG_RANGE_FLOOR  = 2'd3
    } cfg_reg_t;

    // zone machine states, also the reported zone status
    typedef enum logic [2:0] {
        ZONE_CLEAR      = 3'd0,
        ZONE_INSIDE     = 3'd1,
        ZONE_LEAVING    = 3'd2,
        ZONE_OUTER_SEEN = 3'd3,
        ZONE_MANUAL     = 3'd4
    } zone_t;

    // per-sample control of one ghost filter
    typedef struct packed {
        logic step;
        logic hit;
        logic may_clear;
        logic scan_end;
    } zf_ctrl_t;

    // events that drive the zone machine
    typedef struct packed {
        logic scan_end;
        logic toggle;
        logic load_last;
        logic inner_fired;
        logic outer_fired;
    } fsm_ctrl_t;

    // decision reported at a scan end
    typedef struct packed {
        logic  can_move;
        logic  stop_changed;
        zone_t zone_status;
    } fsm_result_t;

endpackage

`default_nettype wire

@@ hdl/lszm_limit_ram.sv @@
// beam limit table: inner and outer limit per beam, one write and one read port
`default_nettype none

module lszm_limit_ram
(
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [lszm_pkg::ADDR_W-1:0]   wr_addr,
    input  wire logic [lszm_pkg::LIMIT_W-1:0]  wr_data,
    input  wire logic                          rd_en,
    input  wire logic [lszm_pkg::ADDR_W-1:0]   rd_addr,
    output logic      [lszm_pkg::LIMIT_W-1:0]  rd_data
);

    logic [lszm_pkg::LIMIT_W-1:0] mem [lszm_pkg::BEAMS];
    logic [lszm_pkg::LIMIT_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/lszm_zone_filter.sv @@
// ghost filter of one zone: hit count, window count and fired flag
`default_nettype none

module lszm_zone_filter
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lszm_pkg::zf_ctrl_t            ctrl,
    input  wire logic [lszm_pkg::HLIM_W-1:0]   hit_limit,
    input  wire logic [lszm_pkg::WLIM_W-1:0]   window_limit,
    output logic                               fired
);

    logic [lszm_pkg::HITS_W-1:0]   hits_reg;
    logic [lszm_pkg::HITS_W-1:0]   hits_next;
    logic [lszm_pkg::WINDOW_W-1:0] window_reg;
    logic [lszm_pkg::WINDOW_W-1:0] window_next;
    logic                          fired_reg;
    logic                          fired_next;
    logic [lszm_pkg::HITS_W-1:0]   hits_upd;
    logic [lszm_pkg::HITS_W-1:0]   hits_sample;
    logic [lszm_pkg::WINDOW_W-1:0] window_sample;
    logic                          fired_sample;
    logic [lszm_pkg::HITS_W-1:0]   hit_limit_ext;
    logic [lszm_pkg::WINDOW_W-1:0] window_limit_ext;

    assign hit_limit_ext    = lszm_pkg::HITS_W'(hit_limit);
    assign window_limit_ext = lszm_pkg::WINDOW_W'(window_limit);
    assign hits_upd         = hits_reg + lszm_pkg::HITS_W'(ctrl.hit);

    // sample update: fire on a hit above the limit, else count, then restart or age the window
    always_comb
    begin
        hits_sample   = hits_reg;
        window_sample = window_reg;
        fired_sample  = fired_reg;
        if (ctrl.step && !fired_reg)
        begin
            if (ctrl.hit && (hits_reg > hit_limit_ext))
            begin
                fired_sample = 1'b1;
            end
            else
            begin
                hits_sample = hits_upd;
                if (ctrl.may_clear && (window_reg > window_limit_ext)
                    && (hits_upd < hit_limit_ext))
                begin
                    hits_sample   = '0;
                    window_sample = lszm_pkg::WINDOW_W'(1);
                end
                else if (window_reg != lszm_pkg::WINDOW_MAX)
                begin
                    window_sample = window_reg + lszm_pkg::WINDOW_W'(1);
                end
            end
        end
    end

    // scan end clears the filter after its last sample
    always_comb
    begin
        hits_next   = hits_sample;
        window_next = window_sample;
        fired_next  = fired_sample;
        if (ctrl.step && ctrl.scan_end)
        begin
            hits_next   = '0;
            window_next = '0;
            fired_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg   <= '0;
            window_reg <= '0;
            fired_reg  <= 1'b0;
        end
        else
        begin
            hits_reg   <= hits_next;
            window_reg <= window_next;
            fired_reg  <= fired_next;
        end
    end

    // fired flag including the current sample, for the scan end decision
    assign fired = fired_sample;

endmodule

`default_nettype wire

@@ hdl/lszm_scan_fsm.sv @@
// zone machine: manual toggle, table ready flag and the move or stop decision
`default_nettype none

module lszm_scan_fsm
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lszm_pkg::fsm_ctrl_t   ctrl,
    output lszm_pkg::zone_t            zone_state,
    output lszm_pkg::fsm_result_t      result
);

    lszm_pkg::zone_t state_reg;
    lszm_pkg::zone_t state_next;
    logic            last_stop_reg;
    logic            last_stop_next;
    logic            tables_ready_reg;
    logic            tables_ready_next;
    lszm_pkg::zone_t dec_state;
    logic            dec_stop;
    logic            decide;

    // a decision is taken at a scan end outside manual mode once tables are loaded
    assign decide = ctrl.scan_end && (state_reg != lszm_pkg::ZONE_MANUAL) && tables_ready_reg;

    // decision from the fired flags
    always_comb
    begin
        dec_state = state_reg;
        dec_stop  = 1'b0;
        if (ctrl.inner_fired)
        begin
            dec_stop = 1'b1;
            if ((state_reg == lszm_pkg::ZONE_LEAVING) || (state_reg == lszm_pkg::ZONE_OUTER_SEEN))
            begin
                dec_state = lszm_pkg::ZONE_INSIDE;
            end
        end
        else if (state_reg == lszm_pkg::ZONE_INSIDE)
        begin
            dec_state = lszm_pkg::ZONE_LEAVING;
            dec_stop  = 1'b1;
        end
        else if (ctrl.outer_fired)
        begin
            if (state_reg == lszm_pkg::ZONE_LEAVING)
            begin
                dec_stop = 1'b1;
            end
            else if (state_reg == lszm_pkg::ZONE_CLEAR)
            begin
                dec_state = lszm_pkg::ZONE_OUTER_SEEN;
            end
            else
            begin
                dec_state = lszm_pkg::ZONE_CLEAR;
            end
        end
        else if (state_reg == lszm_pkg::ZONE_OUTER_SEEN)
        begin
            dec_state = lszm_pkg::ZONE_CLEAR;
        end
    end

    // next state
    always_comb
    begin
        state_next        = state_reg;
        last_stop_next    = last_stop_reg;
        tables_ready_next = tables_ready_reg;
        if (ctrl.toggle)
        begin
            state_next = (state_reg == lszm_pkg::ZONE_MANUAL) ? lszm_pkg::ZONE_CLEAR
                                                               : lszm_pkg::ZONE_MANUAL;
        end
        if (ctrl.load_last)
        begin
            tables_ready_next = 1'b1;
        end
        if (decide)
        begin
            state_next     = dec_state;
            last_stop_next = dec_stop;
        end
    end

    // outputs
    always_comb
    begin
        result.can_move     = 1'b0;
        result.stop_changed = 1'b0;
        result.zone_status  = state_reg;
        if (state_reg == lszm_pkg::ZONE_MANUAL)
        begin
            result.can_move = 1'b1;
        end
        else if (tables_ready_reg)
        begin
            result.can_move     = !dec_stop;
            result.stop_changed = (dec_stop != last_stop_reg);
            result.zone_status  = dec_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lszm_pkg::ZONE_CLEAR;
            last_stop_reg    <= 1'b0;
            tables_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            last_stop_reg    <= last_stop_next;
            tables_ready_reg <= tables_ready_next;
        end
    end

    assign zone_state = state_reg;

endmodule

`default_nettype wire

@@ hdl/lidar_safety_zone_monitor.sv @@
// top level of the lidar safety zone monitor
// a scan end result passes the decision stage and then the result register that drives m_tdata
// throughput: one item per cycle; table read at the input transfer, compare and decision
//   in the decision stage; input stalls only while a scan end waits on a held result
// reset: counters, zone state, table ready and last stop flags clear, registers take
//   their defaults; limit tables are undefined until loaded
`default_nettype none

module lidar_safety_zone_monitor
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // beam_index[9:0], inner_limit_mm[25:10], outer_limit_mm[41:26], range_mm[57:42]
    input  wire logic [63:0] s_tdata,
    // operation[1:0]
    input  wire logic [1:0]  s_tuser,
    // last_beam
    input  wire logic        s_tlast,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // can_move[0], stop_changed[1], zone_status[4:2]
    output logic [7:0]       m_tdata,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // configuration registers
    logic [lszm_pkg::HLIM_W-1:0] hit_limit_reg;
    logic [lszm_pkg::WLIM_W-1:0] window_limit_reg;
    logic [lszm_pkg::DIST_W-1:0] near_floor_reg;
    logic [lszm_pkg::DIST_W-1:0] range_floor_reg;

    // input fields
    lszm_pkg::op_t               in_op;
    logic [lszm_pkg::BEAM_W-1:0] in_beam;
    logic [lszm_pkg::DIST_W-1:0] in_inner;
    logic [lszm_pkg::DIST_W-1:0] in_outer;
    logic [lszm_pkg::DIST_W-1:0] in_range;
    logic                        in_xfer;
    logic                        beam_ok;
    logic                        ram_wr_en;

    // sample index
    logic [lszm_pkg::ADDR_W-1:0] sample_index_reg;
    logic [lszm_pkg::ADDR_W-1:0] sample_index_next;

    // decision stage
    logic                        s2_valid_reg;
    logic                        s2_valid_next;
    lszm_pkg::op_t               s2_op_reg;
    logic [lszm_pkg::DIST_W-1:0] s2_range_reg;
    logic                        s2_last_reg;
    logic                        s2_sample;
    logic                        s2_has_result;
    logic                        s2_advance;
    logic [lszm_pkg::LIMIT_W-1:0] limits;
    logic [lszm_pkg::DIST_W-1:0] inner_lim;
    logic [lszm_pkg::DIST_W-1:0] outer_lim;

    // zone filters and machine
    lszm_pkg::zf_ctrl_t          inner_ctrl;
    lszm_pkg::zf_ctrl_t          outer_ctrl;
    logic                        inner_fired;
    logic                        outer_fired;
    lszm_pkg::fsm_ctrl_t         fsm_ctrl;
    lszm_pkg::zone_t             zone_state;
    lszm_pkg::fsm_result_t       fsm_result;

    // result register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        out_free;
    lszm_pkg::fsm_result_t       out_result_reg;

    // unpack the input transfer
    assign in_op    = lszm_pkg::op_t'(s_tuser);
    assign in_beam  = s_tdata[9:0];
    assign in_inner = s_tdata[25:10];
    assign in_outer = s_tdata[41:26];
    assign in_range = s_tdata[57:42];

    // handshake of the two stages
    assign s2_sample     = (s2_op_reg == lszm_pkg::OP_SAMPLE);
    assign s2_has_result = s2_sample && s2_last_reg;
    assign out_free      = !out_valid_reg || m_tready;
    assign s2_advance    = s2_valid_reg && (!s2_has_result || out_free);
    assign s_tready      = !s2_valid_reg || s2_advance;
    assign in_xfer       = s_tvalid && s_tready;

    // table loads are written at transfer, ahead of any later sample read
    assign beam_ok   = (32'(in_beam) < lszm_pkg::BEAMS);
    assign ram_wr_en = in_xfer && (in_op == lszm_pkg::OP_LOAD) && beam_ok;

    lszm_limit_ram u_limit_ram
    (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (lszm_pkg::ADDR_W'(in_beam)),
        .wr_data ({in_outer, in_inner}),
        .rd_en   (in_xfer),
        .rd_addr (sample_index_reg),
        .rd_data (limits)
    );

    assign inner_lim = limits[lszm_pkg::DIST_W-1:0];
    assign outer_lim = limits[lszm_pkg::LIMIT_W-1:lszm_pkg::DIST_W];

    // sample index advances at each sample transfer, wraps, and clears at a scan end
    always_comb
    begin
        sample_index_next = sample_index_reg;
        if (in_xfer && (in_op == lszm_pkg::OP_SAMPLE))
        begin
            if (s_tlast || (sample_index_reg == lszm_pkg::ADDR_W'(lszm_pkg::BEAMS - 1)))
            begin
                sample_index_next = '0;
            end
            else
            begin
                sample_index_next = sample_index_reg + lszm_pkg::ADDR_W'(1);
            end
        end
    end

    // decision stage valid
    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (in_xfer)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_advance)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            s2_valid_reg     <= 1'b0;
        end
        else
        begin
            sample_index_reg <= sample_index_next;
            s2_valid_reg     <= s2_valid_next;
        end
    end

    // decision stage payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s2_op_reg    <= in_op;
            s2_range_reg <= in_range;
            s2_last_reg  <= s_tlast;
        end
    end

    // hit compares against the table limits and floors
    always_comb
    begin
        inner_ctrl.step      = s2_advance && s2_sample;
        inner_ctrl.hit       = (s2_range_reg < inner_lim) && (s2_range_reg > near_floor_reg);
        inner_ctrl.may_clear = (zone_state == lszm_pkg::ZONE_CLEAR)
                               || (zone_state == lszm_pkg::ZONE_OUTER_SEEN);
        inner_ctrl.scan_end  = s2_last_reg;
        outer_ctrl.step      = s2_advance && s2_sample;
        outer_ctrl.hit       = (s2_range_reg < outer_lim) && (s2_range_reg > range_floor_reg);
        outer_ctrl.may_clear = 1'b1;
        outer_ctrl.scan_end  = s2_last_reg;
    end

    lszm_zone_filter u_inner_filter
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (inner_ctrl),
        .hit_limit    (hit_limit_reg),
        .window_limit (window_limit_reg),
        .fired        (inner_fired)
    );

    lszm_zone_filter u_outer_filter
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (outer_ctrl),
        .hit_limit    (hit_limit_reg),
        .window_limit (window_limit_reg),
        .fired        (outer_fired)
    );

    // zone machine events
    always_comb
    begin
        fsm_ctrl.scan_end    = s2_advance && s2_has_result;
        fsm_ctrl.toggle      = s2_advance && (s2_op_reg == lszm_pkg::OP_TOGGLE);
        fsm_ctrl.load_last   = s2_advance && (s2_op_reg == lszm_pkg::OP_LOAD) && s2_last_reg;
        fsm_ctrl.inner_fired = inner_fired;
        fsm_ctrl.outer_fired = outer_fired;
    end

    lszm_scan_fsm u_scan_fsm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (fsm_ctrl),
        .zone_state (zone_state),
        .result     (fsm_result)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s2_advance && s2_has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_advance && s2_has_result)
        begin
            out_result_reg <= fsm_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg.zone_status, out_result_reg.stop_changed,
                       out_result_reg.can_move};

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_limit_reg    <= lszm_pkg::HIT_LIMIT_RST;
            window_limit_reg <= lszm_pkg::WINDOW_LIMIT_RST;
            near_floor_reg   <= lszm_pkg::NEAR_FLOOR_RST;
            range_floor_reg  <= lszm_pkg::RANGE_FLOOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lszm_pkg::cfg_reg_t'(cfg_index))
                lszm_pkg::CFG_HIT_LIMIT:    hit_limit_reg    <= cfg_data[7:0];
                lszm_pkg::CFG_WINDOW_LIMIT: window_limit_reg <= cfg_data[9:0];
                lszm_pkg::CFG_NEAR_FLOOR:   near_floor_reg   <= cfg_data;
                lszm_pkg::CFG_RANGE_FLOOR:  range_floor_reg  <= cfg_data;
                default:
                begin
                    hit_limit_reg <= hit_limit_reg;
                end
            endcase
        end
    end

    // manual mode always reports move with no change
    a_manual_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_result_reg.zone_status == lszm_pkg::ZONE_MANUAL))
        |-> (out_result_reg.can_move && !out_result_reg.stop_changed))
        else $error("manual result does not allow motion");

    // an empty decision stage never blocks the input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_valid_reg |-> s_tready)
        else $error("input stalled with empty decision stage");

    // a scan end leaving the decision stage shows up as a result
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_advance && s2_has_result) |=> out_valid_reg)
        else $error("scan end result lost");

    // a scan end sample restarts the beam index
    a_index_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (in_op == lszm_pkg::OP_SAMPLE) && s_tlast) |=> (sample_index_reg == '0))
        else $error("sample index not cleared at scan end");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for the lidar safety zone monitor: beam streams checked against a scan decision predictor
`default_nettype none

module tb_top;
    import lszm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 640;

    // one input item as it travels on the input stream
    typedef struct {
        op_t                op;
        logic [BEAM_W-1:0]  beam;
        logic [DIST_W-1:0]  inner;
        logic [DIST_W-1:0]  outer;
        logic [DIST_W-1:0]  rng;
        logic               last;
    } beam_item_t;

    // how a generated range sits against the limits of its beam
    typedef enum int {
        R_FAR,
        R_OUTER,
        R_INNER,
        R_NOISE
    } range_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    lidar_safety_zone_monitor uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predicted monitor state
    logic [DIST_W-1:0]   lim_inner [BEAMS];
    logic [DIST_W-1:0]   lim_outer [BEAMS];
    bit                  loaded [BEAMS];
    zone_t               zone = ZONE_CLEAR;
    logic [ADDR_W-1:0]   scan_pos = '0;
    logic [HITS_W-1:0]   in_hits = '0;
    logic [WINDOW_W-1:0] in_win = '0;
    logic                in_fired = 1'b0;
    logic [HITS_W-1:0]   out_hits = '0;
    logic [WINDOW_W-1:0] out_win = '0;
    logic                out_fired = 1'b0;
    logic                tables_ready = 1'b0;
    logic                stop_held = 1'b0;
    logic [HLIM_W-1:0]   hit_lim = HIT_LIMIT_RST;
    logic [WLIM_W-1:0]   win_lim = WINDOW_LIMIT_RST;
    logic [DIST_W-1:0]   near_floor = NEAR_FLOOR_RST;
    logic [DIST_W-1:0]   range_floor = RANGE_FLOOR_RST;

    // stream bookkeeping
    beam_item_t  items_to_send [$];
    fsm_result_t decisions_due [$];
    int          n_items = 0;
    int          mismatches = 0;
    int          cycles = 0;
    bit          no_gaps = 1'b0;
    bit          s_took = 1'b0;
    int unsigned s_gap = 0;
    int unsigned m_gap = 0;

    // ghost filter of one zone for one sample
    task automatic ghost_filter(input logic hit, input logic may_clear,
                                inout logic [HITS_W-1:0] hits,
                                inout logic [WINDOW_W-1:0] win, inout logic fired);
        if (!fired)
        begin
            if (hit && hits > hit_lim)
                fired = 1'b1;
            else
            begin
                if (hit)
                    hits = hits + 1'b1;
                if (may_clear && win > win_lim && hits < hit_lim)
                begin
                    hits = '0;
                    win = WINDOW_W'(1);
                end
                else if (win != WINDOW_MAX)
                    win = win + 1'b1;
            end
        end
    endtask

    // advance the predicted state by one item, queue the decision of a scan end
    task automatic track_item(input beam_item_t it);
        logic ih;
        logic oh;
        logic stop;
        fsm_result_t r;
        case (it.op)
            OP_LOAD:
            begin
                lim_inner[it.beam] = it.inner;
                lim_outer[it.beam] = it.outer;
                loaded[it.beam] = 1'b1;
                if (it.last)
                    tables_ready = 1'b1;
            end
            OP_TOGGLE:
                zone = (zone == ZONE_MANUAL) ? ZONE_CLEAR : ZONE_MANUAL;
            OP_SAMPLE:
            begin
                ih = it.rng < lim_inner[scan_pos] && it.rng > near_floor;
                oh = it.rng < lim_outer[scan_pos] && it.rng > range_floor;
                ghost_filter(ih, zone == ZONE_CLEAR || zone == ZONE_OUTER_SEEN,
                             in_hits, in_win, in_fired);
                ghost_filter(oh, 1'b1, out_hits, out_win, out_fired);
                scan_pos = scan_pos + 1'b1;
                if (it.last)
                begin
                    r.stop_changed = 1'b0;
                    if (zone == ZONE_MANUAL)
                        r.can_move = 1'b1;
                    else if (!tables_ready)
                        r.can_move = 1'b0;
                    else
                    begin
                        if (in_fired)
                        begin
                            if (zone == ZONE_LEAVING || zone == ZONE_OUTER_SEEN)
                                zone = ZONE_INSIDE;
                            stop = 1'b1;
                        end
                        else if (zone == ZONE_INSIDE)
                        begin
                            zone = ZONE_LEAVING;
                            stop = 1'b1;
                        end
                        else if (out_fired)
                        begin
                            if (zone == ZONE_LEAVING)
                                stop = 1'b1;
                            else
                            begin
                                zone = (zone == ZONE_CLEAR) ? ZONE_OUTER_SEEN : ZONE_CLEAR;
                                stop = 1'b0;
                            end
                        end
                        else
                        begin
                            if (zone == ZONE_OUTER_SEEN)
                                zone = ZONE_CLEAR;
                            stop = 1'b0;
                        end
                        r.can_move = !stop;
                        r.stop_changed = (stop != stop_held);
                        stop_held = stop;
                    end
                    r.zone_status = zone;
                    decisions_due = {decisions_due, r};
                    scan_pos = '0;
                    in_hits = '0;
                    in_win = '0;
                    in_fired = 1'b0;
                    out_hits = '0;
                    out_win = '0;
                    out_fired = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    // idle length for either side: mostly none, some short, a few long
    function automatic int unsigned next_gap();
        if (no_gaps)
            return 0;
        case ($urandom_range(0, 19))
            0: return $urandom_range(10, 40);
            1, 2, 3, 4, 5: return $urandom_range(1, 3);
            default: return 0;
        endcase
    endfunction

    task automatic send_item(input op_t op, input logic [BEAM_W-1:0] beam,
                             input logic [DIST_W-1:0] inner, input logic [DIST_W-1:0] outer,
                             input logic [DIST_W-1:0] rng, input logic last);
        beam_item_t it;
        it.op = op;
        it.beam = beam;
        it.inner = inner;
        it.outer = outer;
        it.rng = rng;
        it.last = last;
        track_item(it);
        items_to_send = {items_to_send, it};
        n_items++;
    endtask

    task automatic send_sample(input logic [DIST_W-1:0] rng, input logic last);
        send_item(OP_SAMPLE, 10'($urandom), 16'($urandom), 16'($urandom), rng, last);
    endtask

    task automatic send_toggle();
        send_item(OP_TOGGLE, 10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom));
    endtask

    // limit pair for one beam: mostly an inner limit below the outer one, sometimes anything
    task automatic load_entry(input logic [BEAM_W-1:0] beam, input logic last);
        int unsigned a;
        int unsigned b;
        case ($urandom_range(0, 9))
            0:
            begin
                a = $urandom_range(0, 65535);
                b = $urandom_range(0, 65535);
            end
            1:
            begin
                a = 65535;
                b = 65535;
            end
            2:
            begin
                a = 0;
                b = $urandom_range(0, 65535);
            end
            default:
            begin
                a = $urandom_range(300, 5000);
                b = a + $urandom_range(100, 8000);
            end
        endcase
        send_item(OP_LOAD, beam, a[15:0], b[15:0], 16'($urandom), last);
    endtask

    // range for the beam at the current scan position
    function automatic logic [DIST_W-1:0] pick_range(input range_kind_t k);
        int unsigned inl;
        int unsigned outl;
        int unsigned lo;
        inl = lim_inner[scan_pos];
        outl = lim_outer[scan_pos];
        case (k)
            R_FAR:
                return ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom_range(outl, 65535));
            R_OUTER:
            begin
                lo = range_floor;
                lo = lo + 1;
                if (inl > lo)
                    lo = inl;
                if (lo < outl)
                    return 16'($urandom_range(lo, outl - 1));
                return 16'($urandom);
            end
            R_INNER:
            begin
                lo = near_floor;
                lo = lo + 1;
                if (lo < inl)
                    return 16'($urandom_range(lo, inl - 1));
                return 16'($urandom);
            end
            default:
            begin
                case ($urandom_range(0, 5))
                    0: return 16'd0;
                    1: return near_floor;
                    2: return range_floor;
                    3: return inl[15:0];
                    4: return outl[15:0];
                    default: return 16'($urandom);
                endcase
            end
        endcase
    endfunction

    // one scan; a missing table entry is loaded before its beam is sampled
    task automatic run_scan(input int len, input range_kind_t kind, input int hit_pct,
                            input bit noisy);
        if (noisy && zone == ZONE_MANUAL && $urandom_range(0, 1) == 0)
            send_toggle();
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(0, 99) == 0)
                send_toggle();
            if (noisy && $urandom_range(0, 49) == 0)
                load_entry(10'($urandom), 1'($urandom));
            if (!loaded[scan_pos])
                load_entry(scan_pos, 1'b0);
            send_sample(pick_range(($urandom_range(0, 99) < hit_pct) ? kind : R_FAR),
                        i == len - 1);
        end
    endtask

    // wait until nothing is in flight
    task automatic wait_idle();
        @(posedge clk);
        while (items_to_send.size() != 0 || s_tvalid || decisions_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HIT_LIMIT: hit_lim = val[HLIM_W-1:0];
            CFG_WINDOW_LIMIT: win_lim = val[WLIM_W-1:0];
            CFG_NEAR_FLOOR: near_floor = val;
            default: range_floor = val;
        endcase
    endtask

    // register value with the extremes and small limits favored
    function automatic logic [15:0] cfg_pick(input cfg_reg_t r);
        case (r)
            CFG_HIT_LIMIT:
                case ($urandom_range(0, 4))
                    0: return 16'd0;
                    1: return 16'd255;
                    2, 3: return 16'($urandom_range(1, 6));
                    default: return 16'($urandom_range(0, 255));
                endcase
            CFG_WINDOW_LIMIT:
                case ($urandom_range(0, 4))
                    0: return 16'd0;
                    1: return 16'd1023;
                    2, 3: return 16'($urandom_range(1, 12));
                    default: return 16'($urandom_range(0, 1023));
                endcase
            default:
                case ($urandom_range(0, 5))
                    0: return 16'd0;
                    1: return 16'hffff;
                    2, 3, 4: return 16'($urandom_range(0, 400));
                    default: return 16'($urandom);
                endcase
        endcase
    endfunction

    // input side: present the next item at the falling edge
    always @(negedge clk)
    begin : drive_items
        beam_item_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_took)
        begin
            if (s_gap != 0)
            begin
                s_gap = s_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (items_to_send.size() != 0)
            begin
                nxt = items_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {6'b0, nxt.rng, nxt.outer, nxt.inner, nxt.beam};
                s_tuser <= nxt.op;
                s_tlast <= nxt.last;
                s_gap = next_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result side: random stalls
    always @(negedge clk)
    begin
        if (m_gap != 0)
        begin
            m_gap = m_gap - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            m_gap = next_gap();
        end
    end

    // sample transfers at the rising edge and check each decision
    always @(posedge clk)
    begin : check_decisions
        fsm_result_t want;
        s_took = s_tvalid && s_tready;
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
        else if (rst_n && m_tvalid && m_tready)
        begin
            if (decisions_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected decision: data %h", m_tdata);
            end
            else
            begin
                want = decisions_due.pop_front();
                if (m_tdata[0] !== want.can_move || m_tdata[1] !== want.stop_changed ||
                    m_tdata[4:2] !== want.zone_status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"decision mismatch: expected move %0b changed %0b zone %0d,",
                                  " got move %0b changed %0b zone %0d"},
                                 want.can_move, want.stop_changed, want.zone_status,
                                 m_tdata[0], m_tdata[1], m_tdata[4:2]);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int base;
        bit first;
        range_kind_t kind;
        int n;
        first = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // partial table without the ready flag
        send_item(OP_LOAD, 10'd0, 16'd1000, 16'd3000, 16'($urandom), 1'b0);
        send_item(OP_LOAD, 10'd1, 16'd1500, 16'd4000, 16'($urandom), 1'b0);
        send_item(OP_LOAD, 10'd2, 16'hffff, 16'hffff, 16'($urandom), 1'b0);
        send_item(OP_LOAD, 10'd3, 16'd0, 16'd0, 16'($urandom), 1'b0);
        // scan end while the tables are not ready: stop without a change
        send_sample(16'd0, 1'b0);
        send_sample(16'hffff, 1'b0);
        send_sample(16'hfffe, 1'b0);
        send_sample(16'd7, 1'b1);
        // manual mode answers move even before the tables are ready
        send_toggle();
        send_sample(16'd500, 1'b1);
        send_toggle();
        // last load at the top beam index marks the tables ready
        send_item(OP_LOAD, 10'h3ff, 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        wait_idle();
        cfg_write(CFG_HIT_LIMIT, 16'd0);
        // walk the zone machine: outer seen, inside, leaving, then inside and leaving again
        run_scan(2, R_OUTER, 100, 1'b0);
        run_scan(2, R_INNER, 100, 1'b0);
        run_scan(2, R_FAR, 0, 1'b0);
        run_scan(2, R_OUTER, 100, 1'b0);
        run_scan(2, R_INNER, 100, 1'b0);
        run_scan(2, R_FAR, 0, 1'b0);
        run_scan(2, R_FAR, 0, 1'b0);
        base = n_items;

        // random phases, each with its own register setting
        while (n_items < base + RANDOM_ITEMS)
        begin
            wait_idle();
            for (int r = 0; r < 4; r++)
                if (first || $urandom_range(0, 1) == 0)
                    cfg_write(cfg_reg_t'(r), cfg_pick(cfg_reg_t'(r)));
            first = 1'b0;
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(4, 48);
                for (int b = 0; b < n; b++)
                    load_entry(10'(b), (b == n - 1) && $urandom_range(0, 1) == 0);
            end
            repeat ($urandom_range(2, 6))
            begin
                kind = range_kind_t'($urandom_range(0, 3));
                run_scan($urandom_range(1, 40), kind, $urandom_range(0, 100), 1'b1);
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && decisions_due.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/lszm_pkg.sv
hdl/lszm_limit_ram.sv
hdl/lszm_zone_filter.sv
hdl/lszm_scan_fsm.sv
hdl/lidar_safety_zone_monitor.sv
tb/tb_top.sv
